FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the day number converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define GDN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("gdn assertion failed");
// Clocked check that also runs during reset.
`define GDN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("gdn assertion failed");
`else
`define GDN_ASSERT(lbl, clk, rst_n, prop)
`define GDN_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/gdn_pkg.sv
// Types, constants and tables of the Gregorian day number converter.
package gdn_pkg;

    // Pipeline: stage 0 is the input register, stage LAST_ST the result register.
    localparam int LAST_ST = 6;

    typedef logic [LAST_ST-1:1] t_dp_en;

    typedef struct packed {
        logic        ok;
        logic [22:0] day_number;
    } t_d2j_res;

    typedef struct packed {
        logic        ok;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_j2d_res;

    localparam logic ACT_DATE_TO_JD = 1'b0;
    localparam logic ACT_JD_TO_DATE = 1'b1;

    localparam logic [13:0] YEAR_LO_EXCL = 14'd1600;
    localparam logic [13:0] YEAR_HI_EXCL = 14'd9999;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;

    // Day numbers of 1601-01-01 and 9998-12-31, the accepted span.
    localparam logic [22:0] JD_MIN = 23'd2305814;
    localparam logic [22:0] JD_MAX = 23'd5373119;

    // Reciprocals: q = (n * M) >> K with M = ceil(2^K / d), exact for the operand widths.
    localparam int Y_K = 22;
    localparam logic [15:0] Y_MAGIC =
        16'(((64'd1 << Y_K) + 64'd100 - 64'd1) / 64'd100);

    localparam logic [24:0] W_OFS = 25'd7468865;
    localparam int W_K = 42;
    localparam logic [24:0] W_MAGIC =
        25'(((64'd1 << W_K) + 64'd146097 - 64'd1) / 64'd146097);

    localparam int C_K = 46;
    localparam logic [30:0] C_MAGIC =
        31'(((64'd1 << C_K) + 64'd36525 - 64'd1) / 64'd36525);

    // 10000 / 306001 folded into one constant: the 10000 scale is exact.
    localparam int E_K = 42;
    localparam logic [37:0] E_KMUL =
        38'((((64'd1 << E_K) + 64'd306001 - 64'd1) / 64'd306001) * 64'd10000);

    // floor(30.6001 * E)
    localparam logic [8:0] F_TAB [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    // Days in month (non leap), zero for codes outside 1..12.
    localparam logic [4:0] MLEN_TAB [16] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    // (153 * m2 + 2) / 5 by calendar month, m2 counting from March.
    localparam logic [8:0] MTERM_TAB [16] = '{
        9'd0,   9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd0,   9'd0,   9'd0
    };

endpackage

FILE: rtl/gdn_date2jd.sv
// Date to day number datapath: two compute stages and a delay line.
module gdn_date2jd import gdn_pkg::*; (
    input  logic        i_clk,
    input  t_dp_en      i_en,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [13:0] i_year,
    output t_d2j_res    o_res
);

    logic        n_march_shift;
    logic [14:0] n_y2;
    logic [30:0] n_prod_q2;
    logic [30:0] n_prod_qy;
    logic        n_base_ok;

    logic [4:0]  r1_day;
    logic [3:0]  r1_month;
    logic [13:0] r1_year;
    logic [14:0] r1_y2;
    logic [7:0]  r1_qy;
    logic [7:0]  r1_q2;
    logic        r1_base;

    logic [13:0] n_rem100;
    logic        n_leap;
    logic [4:0]  n_lim;
    logic [23:0] n_dn;
    t_d2j_res    n_res;

    t_d2j_res    r_res [2:LAST_ST-1];

    always_comb begin
        n_march_shift = (i_month <= MONTH_FEB);
        n_y2      = 15'(i_year) + 15'd4800 - 15'(n_march_shift);
        n_prod_q2 = 31'(n_y2) * 31'(Y_MAGIC);
        n_prod_qy = 31'(i_year) * 31'(Y_MAGIC);
        n_base_ok = (i_year > YEAR_LO_EXCL) && (i_year < YEAR_HI_EXCL) &&
                    (i_month >= MONTH_JAN) && (i_month <= MONTH_DEC);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_day   <= i_day;
            r1_month <= i_month;
            r1_year  <= i_year;
            r1_y2    <= n_y2;
            r1_qy    <= n_prod_qy[Y_K+7:Y_K];
            r1_q2    <= n_prod_q2[Y_K+7:Y_K];
            r1_base  <= n_base_ok;
        end
    end

    always_comb begin
        n_rem100 = r1_year - 14'(14'(r1_qy) * 14'd100);
        n_leap   = ((r1_year[1:0] == 2'd0) && (n_rem100 != 14'd0)) ||
                   ((n_rem100 == 14'd0) && (r1_qy[1:0] == 2'd0));
        n_lim    = MLEN_TAB[r1_month] + 5'(n_leap && (r1_month == MONTH_FEB));
        n_dn     = 24'(r1_y2) * 24'd365 + 24'(r1_y2 >> 2) - 24'(r1_q2)
                 + 24'(r1_q2 >> 2) + 24'(MTERM_TAB[r1_month]) + 24'(r1_day)
                 - 24'd32045;
        n_res.ok = r1_base && (r1_day >= 5'd1) && (r1_day <= n_lim);
        n_res.day_number = n_res.ok ? n_dn[22:0] : 23'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_res[2] <= n_res;
        end
        for (int k = 3; k < LAST_ST; k++) begin
            if (i_en[k]) begin
                r_res[k] <= r_res[k-1];
            end
        end
    end

    assign o_res = r_res[LAST_ST-1];

endmodule

FILE: rtl/gdn_jd2date.sv
// Day number to date datapath, Meeus method with reciprocal multiplies.
module gdn_jd2date import gdn_pkg::*; (
    input  logic        i_clk,
    input  t_dp_en      i_en,
    input  logic [22:0] i_day_number,
    output t_j2d_res    o_res
);

    logic [24:0] n_w_num;
    logic [48:0] n_prod_w;
    logic [22:0] n_b;
    logic [29:0] n_c_num;
    logic [60:0] n_prod_c;
    logic [24:0] n_prod_d;
    logic [22:0] n_b_minus_d;
    logic [47:0] n_prod_e;
    logic [9:0]  n_day_full;
    logic [3:0]  n_mon;
    logic [13:0] n_yr;

    logic [22:0] r1_z;
    logic [6:0]  r1_w;
    logic        r1_ok;
    logic [22:0] r2_b;
    logic [29:0] r2_c_num;
    logic        r2_ok;
    logic [22:0] r3_b;
    logic [13:0] r3_c;
    logic        r3_ok;
    logic [9:0]  r4_dd;
    logic [13:0] r4_c;
    logic        r4_ok;
    logic [3:0]  r5_e;
    logic [9:0]  r5_dd;
    logic [13:0] r5_c;
    logic        r5_ok;

    // W = floor((4Z - 7468865) / 146097); exact inside the accepted span.
    always_comb begin
        n_w_num  = {i_day_number, 2'b00} - W_OFS;
        n_prod_w = 49'(n_w_num[23:0]) * 49'(W_MAGIC);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_z  <= i_day_number;
            r1_w  <= n_prod_w[W_K+6:W_K];
            r1_ok <= (i_day_number >= JD_MIN) && (i_day_number <= JD_MAX);
        end
    end

    // B = Z + 1 + W - W/4 + 1524, then 100B - 12210
    always_comb begin
        n_b     = r1_z + 23'd1525 + 23'(r1_w) - 23'(r1_w >> 2);
        n_c_num = 30'(n_b) * 30'd100 - 30'd12210;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_b     <= n_b;
            r2_c_num <= n_c_num;
            r2_ok    <= r1_ok;
        end
    end

    assign n_prod_c = 61'(r2_c_num) * 61'(C_MAGIC);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_b  <= r2_b;
            r3_c  <= n_prod_c[C_K+13:C_K];
            r3_ok <= r2_ok;
        end
    end

    // D = floor(1461C / 4)
    always_comb begin
        n_prod_d    = 25'(r3_c) * 25'd1461;
        n_b_minus_d = r3_b - n_prod_d[24:2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_dd <= n_b_minus_d[9:0];
            r4_c  <= r3_c;
            r4_ok <= r3_ok;
        end
    end

    assign n_prod_e = 48'(r4_dd) * 48'(E_KMUL);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_e  <= n_prod_e[E_K+3:E_K];
            r5_dd <= r4_dd;
            r5_c  <= r4_c;
            r5_ok <= r4_ok;
        end
    end

    always_comb begin
        n_day_full = r5_dd - 10'(F_TAB[r5_e]);
        n_mon      = (r5_e < 4'd14) ? (r5_e - 4'd1) : (r5_e - 4'd13);
        n_yr       = ((n_mon == MONTH_JAN) || (n_mon == MONTH_FEB)) ?
                     (r5_c - 14'd4715) : (r5_c - 14'd4716);
        o_res.ok    = r5_ok;
        o_res.day   = r5_ok ? n_day_full[4:0] : 5'd0;
        o_res.month = r5_ok ? n_mon : 4'd0;
        o_res.year  = r5_ok ? n_yr : 14'd0;
    end

endmodule

FILE: rtl/gregorian_day_number_converter.sv
// Top level: Gregorian date <-> Julian day number converter pipeline.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  input   | in        | i_in_valid / o_in_ready    | action, day, month, year, day_number
//  output  | out       | o_out_valid / i_out_ready  | valid_res, day_number_out, day_out,
//          |           |                            | month_out, year_out
//
// One word per cycle sustained while the output takes words. An accepted word passes
// the input register, five datapath stages and the result register. The depth is set
// by the day-number-to-date path, whose reciprocal multiplies and the multiply by 1461
// each end in a register.
// Reset (i_rst_n low, synchronous) empties the pipeline; payload registers keep junk.
// A stalled output only blocks stages that are full; bubbles in front still close up.
module gregorian_day_number_converter import gdn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [13:0] i_year,
    input  logic [22:0] i_day_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_valid_res,
    output logic [22:0] o_day_number_out,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [13:0] o_year_out
);

`include "assert_macros.svh"

    // Per-stage occupancy and load enables.
    logic [LAST_ST:0]   r_vld;
    logic [LAST_ST:0]   n_adv;

    // Stage 0: input word register.
    logic [LAST_ST-1:0] r_act;
    logic [4:0]         r_day;
    logic [3:0]         r_month;
    logic [13:0]        r_year;
    logic [22:0]        r_day_number;

    t_d2j_res           d2j_res;
    t_j2d_res           j2d_res;

    // A stage may load when it is empty or its content moves on this edge.
    always_comb begin
        n_adv[LAST_ST] = !r_vld[LAST_ST] || i_out_ready;
        for (int k = LAST_ST - 1; k >= 0; k--) begin
            n_adv[k] = !r_vld[k] || n_adv[k+1];
        end
    end

    assign o_in_ready  = n_adv[0];
    assign o_out_valid = r_vld[LAST_ST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k <= LAST_ST; k++) begin
                if (n_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_act[0]     <= i_action;
            r_day        <= i_day;
            r_month      <= i_month;
            r_year       <= i_year;
            r_day_number <= i_day_number;
        end
        // action code travels beside the datapaths to pick the result
        for (int k = 1; k < LAST_ST; k++) begin
            if (n_adv[k]) begin
                r_act[k] <= r_act[k-1];
            end
        end
    end

    gdn_date2jd u_date2jd (
        .i_clk   (i_clk),
        .i_en    (n_adv[LAST_ST-1:1]),
        .i_day   (r_day),
        .i_month (r_month),
        .i_year  (r_year),
        .o_res   (d2j_res)
    );

    gdn_jd2date u_jd2date (
        .i_clk        (i_clk),
        .i_en         (n_adv[LAST_ST-1:1]),
        .i_day_number (r_day_number),
        .o_res        (j2d_res)
    );

    // Result register; fields of the other action read zero.
    always_ff @(posedge i_clk) begin
        if (n_adv[LAST_ST]) begin
            if (r_act[LAST_ST-1] == ACT_JD_TO_DATE) begin
                o_valid_res      <= j2d_res.ok;
                o_day_number_out <= 23'd0;
                o_day_out        <= j2d_res.day;
                o_month_out      <= j2d_res.month;
                o_year_out       <= j2d_res.year;
            end else begin
                o_valid_res      <= d2j_res.ok;
                o_day_number_out <= d2j_res.day_number;
                o_day_out        <= 5'd0;
                o_month_out      <= 4'd0;
                o_year_out       <= 14'd0;
            end
        end
    end

    // Input stalls only when every stage holds a word.
    `GDN_ASSERT(a_stall_full, i_clk, i_rst_n, !o_in_ready |-> (&r_vld))
    // A rejected word carries all-zero fields.
    `GDN_ASSERT(a_invalid_zero, i_clk, i_rst_n,
        (o_out_valid && !o_valid_res) |->
        ((o_day_number_out == 23'd0) && (o_day_out == 5'd0) &&
         (o_month_out == 4'd0) && (o_year_out == 14'd0)))
    // A converted date never also carries a day number, and its month is real.
    `GDN_ASSERT(a_date_fields, i_clk, i_rst_n,
        (o_out_valid && o_valid_res && (o_day_number_out == 23'd0)) |->
        ((o_month_out >= MONTH_JAN) && (o_month_out <= MONTH_DEC) && (o_day_out != 5'd0)))
    // Reset leaves the output empty.
    `GDN_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

FILE: tb/tb.sv
// Testbench for the Gregorian date / Julian day number converter, with self-checking prediction.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gdn_pkg::*;

    // Accepted calendar span, exclusive on both ends.
    localparam longint FIRST_BAD_YEAR = 1600;
    localparam longint LAST_BAD_YEAR  = 9999;

    // Cycles with no word moving on either side before the run is abandoned.
    // The worst legal quiet stretch is the receiver hold-off below (HOLD_CYCLES).
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    // Seven-stage pipe: settle margin after the last word.
    localparam int SETTLE_CYCLES = 12;

    // One result word, as compared field by field.
    typedef struct packed {
        logic        ok;
        logic [22:0] day_number;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_calendar_word;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic        i_action         = ACT_DATE_TO_JD;
    logic [4:0]  i_day            = '0;
    logic [3:0]  i_month          = '0;
    logic [13:0] i_year           = '0;
    logic [22:0] i_day_number     = '0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic        o_valid_res;
    logic [22:0] o_day_number_out;
    logic [4:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [13:0] o_year_out;

    // Conversions accepted at the input and not yet seen at the output, oldest first.
    t_calendar_word pending_conversions[$];

    int mismatch_count = 0;
    int words_checked  = 0;
    int quiet_cycles   = 0;

    // Idle odds per cycle, in percent, for the sender and the receiver.
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    // Receiver hold-off request; picked up and counted down by the receiver process.
    int hold_request = 0;
    int hold_left    = 0;

    gregorian_day_number_converter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_day            (i_day),
        .i_month          (i_month),
        .i_year           (i_year),
        .i_day_number     (i_day_number),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_valid_res      (o_valid_res),
        .o_day_number_out (o_day_number_out),
        .o_day_out        (o_day_out),
        .o_month_out      (o_month_out),
        .o_year_out       (o_year_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------

    // Division rounded toward minus infinity; SV '/' truncates toward zero.
    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit leap_year(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint days_in_month(longint m, bit leap);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Expected result word for one input word.
    function automatic t_calendar_word convert_calendar(logic act, logic [4:0] dd,
                                                        logic [3:0] mm, logic [13:0] yy,
                                                        logic [22:0] jd);
        t_calendar_word r;
        longint d, m, y, a, y2, m2, sum;
        longint z, w, x, b, c, dq, e, f, mon, yr;
        bit ok;
        r = '0;
        d = dd;
        m = mm;
        y = yy;
        if (act == ACT_DATE_TO_JD) begin
            // Month range is settled before the month length is looked at.
            ok = (y > FIRST_BAD_YEAR) && (y < LAST_BAD_YEAR) && (m >= 1) && (m <= 12);
            if (ok)
                ok = (d >= 1) && (d <= days_in_month(m, leap_year(y)));
            if (ok) begin
                a   = (m <= 2) ? 1 : 0;
                y2  = y + 4800 - a;
                m2  = m + 12 * a - 3;
                sum = d + (153 * m2 + 2) / 5 + 365 * y2 + y2 / 4 - y2 / 100 + y2 / 400
                      - 32045;
                r.ok         = 1'b1;
                r.day_number = 23'(sum);
            end
        end else begin
            // Meeus inversion in scaled integers, every quotient floored.
            z   = jd;
            w   = floor_div(4 * z - 7468865, 146097);
            x   = floor_div(w, 4);
            b   = z + 1 + w - x + 1524;
            c   = floor_div(100 * b - 12210, 36525);
            dq  = floor_div(1461 * c, 4);
            e   = floor_div(10000 * (b - dq), 306001);
            f   = floor_div(306001 * e, 10000);
            mon = (e < 14) ? e - 1 : e - 13;
            yr  = (mon == 1 || mon == 2) ? c - 4715 : c - 4716;
            if (yr > FIRST_BAD_YEAR && yr < LAST_BAD_YEAR) begin
                r.ok    = 1'b1;
                r.day   = 5'(b - dq - f);
                r.month = 4'(mon);
                r.year  = 14'(yr);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t word %0d: %s", $realtime, words_checked, msg);
        mismatch_count++;
    endtask

    // Every word leaving the block is compared with the oldest pending conversion.
    always @(posedge i_clk) begin : result_check
        t_calendar_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_conversions.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = pending_conversions.pop_front();
                if (o_valid_res !== want.ok)
                    report_mismatch($sformatf("valid_res got %0d want %0d",
                                              o_valid_res, want.ok));
                if (o_day_number_out !== want.day_number)
                    report_mismatch($sformatf("day_number_out got %0d want %0d",
                                              o_day_number_out, want.day_number));
                if (o_day_out !== want.day)
                    report_mismatch($sformatf("day_out got %0d want %0d",
                                              o_day_out, want.day));
                if (o_month_out !== want.month)
                    report_mismatch($sformatf("month_out got %0d want %0d",
                                              o_month_out, want.month));
                if (o_year_out !== want.year)
                    report_mismatch($sformatf("year_out got %0d want %0d",
                                              o_year_out, want.year));
            end
            words_checked++;
        end
    end

    // Watchdog: any handshake on either side resets the quiet count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("gregorian_day_number_converter: mismatch");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random back-pressure, or a long counted hold-off when asked for.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else
                i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one word, with a random idle gap first; returns at the edge that takes it.
    // Valid stays high on return so back-to-back words need no extra edge.
    task automatic send_word(logic act, logic [4:0] dd, logic [3:0] mm,
                             logic [13:0] yy, logic [22:0] jd);
        if ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_day        <= dd;
        i_month      <= mm;
        i_year       <= yy;
        i_day_number <= jd;
        do @(posedge i_clk); while (!o_in_ready);
        pending_conversions.push_back(convert_calendar(act, dd, mm, yy, jd));
    endtask

    // Sender goes quiet until every pending conversion has come out.
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending_conversions.size() != 0)
            @(posedge i_clk);
    endtask

    // Random date: mostly well-formed, some near the year edges, some pure noise.
    task automatic send_random_date();
        logic [4:0]  dd;
        logic [3:0]  mm;
        logic [13:0] yy;
        int unsigned pick;
        dd   = 5'($urandom);
        mm   = 4'($urandom);
        yy   = 14'($urandom);
        pick = $urandom_range(99);
        if (pick < 85) begin
            if (pick < 10)
                yy = 14'($urandom_range(1595, 1606));
            else if (pick < 20)
                yy = 14'($urandom_range(9993, 10004));
            else
                yy = 14'($urandom_range(1601, 9998));
            mm = 4'($urandom_range(1, 12));
            // Mostly in-month days, now and then one past the end of the month.
            if ($urandom_range(9) == 0)
                dd = 5'(days_in_month(mm, leap_year(yy)) + 1);
            else
                dd = 5'($urandom_range(1, days_in_month(mm, leap_year(yy))));
        end
        send_word(ACT_DATE_TO_JD, dd, mm, yy, 23'($urandom));
    endtask

    // Random day number: mostly around the accepted span, some over the full width.
    task automatic send_random_day_number();
        logic [22:0] jd;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            jd = 23'($urandom);
        else if (pick < 25)
            jd = 23'($urandom_range(JD_MIN - 400, JD_MIN + 400));
        else if (pick < 35)
            jd = 23'($urandom_range(JD_MAX - 400, JD_MAX + 400));
        else
            jd = 23'($urandom_range(JD_MIN, JD_MAX));
        send_word(ACT_JD_TO_DATE, 5'($urandom), 4'($urandom), 14'($urandom), jd);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Date to day number: year, month and day limits, and the leap rule.
    task automatic test_date_edges();
        send_word(ACT_DATE_TO_JD, 5'd1,  MONTH_JAN, 14'd1601,  '0);  // first accepted day
        send_word(ACT_DATE_TO_JD, 5'd31, MONTH_DEC, 14'd9998,  '0);  // last accepted day
        send_word(ACT_DATE_TO_JD, 5'd15, 4'd6,      YEAR_LO_EXCL, '0);
        send_word(ACT_DATE_TO_JD, 5'd1,  MONTH_JAN, YEAR_HI_EXCL, '0);
        send_word(ACT_DATE_TO_JD, 5'd0,  4'd0,      14'd0,     '0);  // all zero
        send_word(ACT_DATE_TO_JD, 5'd31, 4'd15,     14'd16383, '1);  // all ones
        send_word(ACT_DATE_TO_JD, 5'd10, 4'd13,     14'd2000,  '0);  // month past December
        send_word(ACT_DATE_TO_JD, 5'd10, 4'd0,      14'd2000,  '0);  // month zero
        send_word(ACT_DATE_TO_JD, 5'd0,  MONTH_JAN, 14'd2000,  '0);  // day zero
        send_word(ACT_DATE_TO_JD, 5'd31, MONTH_JAN, 14'd2000,  '0);
        send_word(ACT_DATE_TO_JD, 5'd31, 4'd4,      14'd2000,  '0);  // 31 in a 30-day month
        send_word(ACT_DATE_TO_JD, 5'd29, MONTH_FEB, 14'd2000,  '0);  // leap by 400 rule
        send_word(ACT_DATE_TO_JD, 5'd29, MONTH_FEB, 14'd1900,  '0);  // century, not leap
        send_word(ACT_DATE_TO_JD, 5'd29, MONTH_FEB, 14'd2024,  '0);
        send_word(ACT_DATE_TO_JD, 5'd29, MONTH_FEB, 14'd2023,  '0);
        send_word(ACT_DATE_TO_JD, 5'd28, MONTH_FEB, 14'd2100,  '0);
        drain_pipe();
    endtask

    // Day number to date: width extremes, span edges, January/February month repair.
    task automatic test_day_number_edges();
        send_word(ACT_JD_TO_DATE, '0, '0, '0, 23'd0);
        send_word(ACT_JD_TO_DATE, '1, '1, '1, 23'd8388607);
        send_word(ACT_JD_TO_DATE, '0, '0, '0, JD_MIN - 23'd1);   // 1600-12-31, rejected
        send_word(ACT_JD_TO_DATE, '0, '0, '0, JD_MIN);
        send_word(ACT_JD_TO_DATE, '0, '0, '0, JD_MAX);
        send_word(ACT_JD_TO_DATE, '0, '0, '0, JD_MAX + 23'd1);   // 9999-01-01, rejected
        send_word(ACT_JD_TO_DATE, '0, '0, '0, 23'd2451545);      // 2000-01-01, E = 14
        send_word(ACT_JD_TO_DATE, '0, '0, '0, 23'd2451604);      // 2000-02-29, E = 15
        send_word(ACT_JD_TO_DATE, '0, '0, '0, 23'd2451605);      // 2000-03-01, E = 4
        drain_pipe();
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing,
    // so the pipe fills and input ready drops; then the sender waits it out.
    task automatic test_output_stall();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (40) begin
            if ($urandom_range(1))
                send_random_date();
            else
                send_random_day_number();
        end
        drain_pipe();
    endtask

    // Mixed random words under the given idle odds.
    task automatic test_random_mix(int unsigned n_words, int unsigned src_pct,
                                   int unsigned sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (n_words) begin
            if ($urandom_range(1))
                send_random_date();
            else
                send_random_day_number();
        end
        drain_pipe();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 38;
        sink_idle_pct = 87;
        test_date_edges();
        test_day_number_edges();
        test_random_mix(450, 38, 87);
        test_random_mix(450, 87, 38);
        test_random_mix(450, 0, 0);
        test_output_stall();

        // Latency margin after the last word; catches stray extra outputs.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_conversions.size() != 0)
            report_mismatch($sformatf("%0d conversions never came out",
                                      pending_conversions.size()));
        if (mismatch_count == 0)
            $display("gregorian_day_number_converter: match");
        else
            $display("gregorian_day_number_converter: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/gdn_pkg.sv
rtl/gdn_date2jd.sv
rtl/gdn_jd2date.sv
rtl/gregorian_day_number_converter.sv
tb/tb.sv
